// ===== sv/cadpcm_pkg.sv =====
// Shared types, constants and coefficient tables for the block ADPCM decoder.
`default_nettype none

package cadpcm_pkg;

  localparam int HistW           = 40;
  localparam int DefHistFracBits = 16;
  localparam int CoefW           = 8;

  // Byte positions inside a 16-byte block
  localparam logic [3:0] PosHeader = 4'd0;
  localparam logic [3:0] PosFlags  = 4'd1;
  localparam logic [3:0] PosLast   = 4'd15;

  localparam logic [7:0] FlagEnd   = 8'd7;

  typedef enum logic {
    KindSample = 1'b0,
    KindEnd    = 1'b1
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_sample;
  } in_t;

  typedef struct packed {
    logic signed [15:0] pcm_sample;
    kind_e              result_kind;
    logic               loop_start_mark;
    logic               loop_end_mark;
    logic               release_mark;
    logic               last_of_run;
  } out_t;

  // Filter weights in 1/64 units; unused predictor codes act as zero
  function automatic logic signed [CoefW-1:0] coef_new(logic [2:0] p);
    logic signed [CoefW-1:0] c;
    case (p)
      3'd1:    c = 8'sd60;
      3'd2:    c = 8'sd115;
      3'd3:    c = 8'sd98;
      3'd4:    c = 8'sd122;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [CoefW-1:0] coef_old(logic [2:0] p);
    logic signed [CoefW-1:0] c;
    case (p)
      3'd2:    c = -8'sd52;
      3'd3:    c = -8'sd55;
      3'd4:    c = -8'sd60;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/cadpcm_step.sv =====
// One nibble through the predictor: shift, multiply-add, saturate, round.
`default_nettype none

module cadpcm_step #(
  parameter int HistFracBits = cadpcm_pkg::DefHistFracBits
) (
  input  wire logic [3:0]                           nib_i,
  input  wire logic [3:0]                           shift_i,
  input  wire logic [2:0]                           pred_i,
  input  wire logic signed [cadpcm_pkg::HistW-1:0]  hist_new_i,
  input  wire logic signed [cadpcm_pkg::HistW-1:0]  hist_old_i,
  output logic signed [cadpcm_pkg::HistW-1:0]       hist_o,
  output logic signed [15:0]                        pcm_o
);

  localparam int HW   = cadpcm_pkg::HistW;
  localparam int SumW = HW + 10;
  localparam int RW   = HW + 1;

  localparam logic signed [SumW-1:0] HistMax = (SumW'(64'sd1) <<< (HW - 1)) - SumW'(64'sd1);
  localparam logic signed [SumW-1:0] HistMin = ~HistMax;
  localparam logic signed [RW-1:0]   RndHalf = RW'(64'sd1) <<< (HistFracBits - 1);
  localparam logic signed [RW-1:0]   NegHalf = -RndHalf;
  // bias that rounds by one half and then truncates toward zero for negatives
  localparam logic signed [RW-1:0]   NegBias = RndHalf + (RW'(64'sd1) <<< HistFracBits)
                                               - RW'(64'sd1);
  localparam logic signed [RW-1:0]   PcmMax  = RW'(64'sd32767);
  localparam logic signed [RW-1:0]   PcmMin  = RW'(-64'sd32768);

  logic signed [15:0]       nib_ext;
  logic signed [15:0]       delta;
  logic signed [SumW-1:0]   prod_new;
  logic signed [SumW-1:0]   prod_old;
  logic signed [SumW-1:0]   acc;
  logic signed [RW-1:0]     hist_ext;
  logic signed [RW-1:0]     rsum;
  logic signed [RW-1:0]     q;

  assign nib_ext  = {nib_i, 12'b0};
  assign delta    = nib_ext >>> shift_i;

  assign prod_new = SumW'(cadpcm_pkg::coef_new(pred_i)) * SumW'(hist_new_i);
  assign prod_old = SumW'(cadpcm_pkg::coef_old(pred_i)) * SumW'(hist_old_i);
  assign acc      = (SumW'(delta) <<< HistFracBits) + ((prod_new + prod_old) >>> 6);

  always_comb begin
    if (acc > HistMax) begin
      hist_o = HistMax[HW-1:0];
    end else if (acc < HistMin) begin
      hist_o = HistMin[HW-1:0];
    end else begin
      hist_o = acc[HW-1:0];
    end
  end

  assign hist_ext = RW'(hist_o);
  assign rsum     = hist_ext + ((hist_ext < NegHalf) ? NegBias : RndHalf);
  assign q        = rsum >>> HistFracBits;

  always_comb begin
    if (q > PcmMax) begin
      pcm_o = PcmMax[15:0];
    end else if (q < PcmMin) begin
      pcm_o = PcmMin[15:0];
    end else begin
      pcm_o = q[15:0];
    end
  end

endmodule

`default_nettype wire

// ===== sv/console_adpcm_block_decoder.sv =====
// Top level of the block ADPCM decoder: block parsing, nibble sequencing, output register.
//
//   channel | direction | handshake                | beat payload
//   --------+-----------+--------------------------+------------------------------
//   in      | input     | in_valid_i / in_ready_o  | cadpcm_pkg::in_t  (one byte)
//   out     | output    | out_valid_o / out_ready_i| cadpcm_pkg::out_t (one sample)
//
// A data byte's two nibbles go one per cycle, while the output is not stalled,
// through the single predictor multiply-add in cadpcm_step. Header, leading-block,
// ignored and non-end flag bytes do not enter the nibble sequencer; a new byte is
// accepted in the cycle the previous one finishes. A data byte is registered in the
// nibble sequencer, each of its results then in the output register, low nibble first.
// Reset clears all control state and the history; no clearing pass is needed.
// A stalled output holds the nibble sequencer, which then holds the input.
`default_nettype none

module console_adpcm_block_decoder #(
  parameter int HistFracBits = cadpcm_pkg::DefHistFracBits
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire cadpcm_pkg::in_t  in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output cadpcm_pkg::out_t      out_data_o
);

  localparam int HW = cadpcm_pkg::HistW;

  // block parser state
  logic [3:0]            pos_q, pos_d;
  logic                  lead_q, lead_d;
  logic                  stopped_q, stopped_d;
  logic [3:0]            shift_q, shift_d;
  logic [2:0]            pred_q, pred_d;
  logic [2:0]            flags_q, flags_d;
  logic signed [HW-1:0]  hist_new_q, hist_new_d;
  logic signed [HW-1:0]  hist_old_q, hist_old_d;

  // nibble sequencer
  logic                  wrk_valid_q, wrk_valid_d;
  logic                  wrk_end_q, wrk_end_d;
  logic                  wrk_phase_q, wrk_phase_d;
  logic [7:0]            wrk_byte_q, wrk_byte_d;

  logic                  out_valid_q, out_valid_d;
  cadpcm_pkg::out_t      out_q, out_d;

  logic                  in_fire;
  logic                  advance;
  logic                  done;
  logic                  start;
  logic [3:0]            eff_pos;
  logic                  eff_lead;
  logic                  eff_stop;
  logic [3:0]            nib;
  logic signed [HW-1:0]  step_hist;
  logic signed [15:0]    step_pcm;

  assign advance    = wrk_valid_q && (!out_valid_q || out_ready_i);
  assign done       = advance && (wrk_end_q || wrk_phase_q);
  assign in_ready_o = !wrk_valid_q || done;
  assign in_fire    = in_valid_i && in_ready_o;

  assign start    = in_data_i.start_of_sample;
  assign eff_pos  = start ? cadpcm_pkg::PosHeader : pos_q;
  assign eff_lead = start || lead_q;
  assign eff_stop = !start && stopped_q;

  assign nib = wrk_phase_q ? wrk_byte_q[7:4] : wrk_byte_q[3:0];

  cadpcm_step #(
    .HistFracBits (HistFracBits)
  ) u_step (
    .nib_i      (nib),
    .shift_i    (shift_q),
    .pred_i     (pred_q),
    .hist_new_i (hist_new_q),
    .hist_old_i (hist_old_q),
    .hist_o     (step_hist),
    .pcm_o      (step_pcm)
  );

  always_comb begin
    pos_d       = pos_q;
    lead_d      = lead_q;
    stopped_d   = stopped_q;
    shift_d     = shift_q;
    pred_d      = pred_q;
    flags_d     = flags_q;
    hist_new_d  = hist_new_q;
    hist_old_d  = hist_old_q;
    wrk_valid_d = wrk_valid_q;
    wrk_end_d   = wrk_end_q;
    wrk_phase_d = wrk_phase_q;
    wrk_byte_d  = wrk_byte_q;

    // the nibble in flight uses the history before any start mark clears it
    if (advance && !wrk_end_q) begin
      hist_old_d = hist_new_q;
      hist_new_d = step_hist;
    end
    if (done) begin
      wrk_valid_d = 1'b0;
    end else if (advance) begin
      wrk_phase_d = 1'b1;
    end

    if (in_fire) begin
      if (start) begin
        pos_d      = cadpcm_pkg::PosHeader;
        lead_d     = 1'b1;
        stopped_d  = 1'b0;
        hist_new_d = '0;
        hist_old_d = '0;
      end
      if (!eff_stop) begin
        pos_d = eff_pos + 4'd1;
        if (eff_lead) begin
          if (eff_pos == cadpcm_pkg::PosLast) begin
            lead_d = 1'b0;
          end
        end else if (eff_pos == cadpcm_pkg::PosHeader) begin
          shift_d = in_data_i.data_byte[3:0];
          pred_d  = (in_data_i.data_byte[7:4] <= 4'd4) ? in_data_i.data_byte[6:4] : 3'd0;
        end else if (eff_pos == cadpcm_pkg::PosFlags) begin
          if (in_data_i.data_byte == cadpcm_pkg::FlagEnd) begin
            stopped_d   = 1'b1;
            pos_d       = cadpcm_pkg::PosHeader;
            wrk_valid_d = 1'b1;
            wrk_end_d   = 1'b1;
            wrk_phase_d = 1'b0;
          end else begin
            flags_d = in_data_i.data_byte[2:0];
          end
        end else begin
          wrk_valid_d = 1'b1;
          wrk_end_d   = 1'b0;
          wrk_phase_d = 1'b0;
          wrk_byte_d  = in_data_i.data_byte;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance) begin
      out_valid_d = 1'b1;
      if (wrk_end_q) begin
        out_d.pcm_sample      = '0;
        out_d.result_kind     = cadpcm_pkg::KindEnd;
        out_d.loop_start_mark = 1'b0;
        out_d.loop_end_mark   = 1'b0;
        out_d.release_mark    = 1'b0;
        out_d.last_of_run     = 1'b1;
      end else begin
        out_d.pcm_sample      = step_pcm;
        out_d.result_kind     = cadpcm_pkg::KindSample;
        out_d.loop_start_mark = flags_q[2];
        out_d.loop_end_mark   = flags_q[0];
        out_d.release_mark    = flags_q[0] && !flags_q[1];
        out_d.last_of_run     = wrk_phase_q;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= cadpcm_pkg::PosHeader;
      lead_q      <= 1'b1;
      stopped_q   <= 1'b0;
      shift_q     <= '0;
      pred_q      <= '0;
      flags_q     <= '0;
      hist_new_q  <= '0;
      hist_old_q  <= '0;
      wrk_valid_q <= 1'b0;
      wrk_end_q   <= 1'b0;
      wrk_phase_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      lead_q      <= lead_d;
      stopped_q   <= stopped_d;
      shift_q     <= shift_d;
      pred_q      <= pred_d;
      flags_q     <= flags_d;
      hist_new_q  <= hist_new_d;
      hist_old_q  <= hist_old_d;
      wrk_valid_q <= wrk_valid_d;
      wrk_end_q   <= wrk_end_d;
      wrk_phase_q <= wrk_phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    wrk_byte_q <= wrk_byte_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== sv/cadpcm_checker.sv =====
// Port-level checks for the block ADPCM decoder, bound to the top level.
`default_nettype none

module cadpcm_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire cadpcm_pkg::in_t  in_data_i,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire cadpcm_pkg::out_t out_data_o
);

  // hold a stalled output beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed or dropped");

  a_end_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == cadpcm_pkg::KindEnd |->
      out_data_o.pcm_sample == 16'sd0 && out_data_o.last_of_run &&
      !out_data_o.loop_start_mark && !out_data_o.loop_end_mark && !out_data_o.release_mark)
    else $error("end beat carries sample data or marks");

  a_release_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.release_mark |-> out_data_o.loop_end_mark)
    else $error("release mark without loop end mark");

  // a first-nibble beat is followed at once by the second nibble of the same byte
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last_of_run |=>
      out_valid_o && out_data_o.last_of_run &&
      out_data_o.result_kind == cadpcm_pkg::KindSample)
    else $error("first nibble beat not followed by its pair");

endmodule

bind console_adpcm_block_decoder cadpcm_checker u_cadpcm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking bench, block ADPCM decoder: directed script, then random samples and noise bursts.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     Frac          = cadpcm_pkg::DefHistFracBits;
  localparam longint HistMax       = (longint'(1) <<< (cadpcm_pkg::HistW - 1)) - 1;
  localparam longint HistMin       = -HistMax - 1;
  localparam int     NumFilters    = 5;
  localparam int     IdlePct       = 22;
  localparam int     ItemTarget    = 1300;
  localparam int     HoldOffCycles = 300;
  localparam int     HoldOffAfter  = 200;
  localparam int     StallLimit    = 4000;
  localparam int     DrainCycles   = 20;

  localparam longint WeightNew [NumFilters] = '{0, 60, 115, 98, 122};
  localparam longint WeightOld [NumFilters] = '{0, 0, -52, -55, -60};

  localparam cadpcm_pkg::out_t Quiet   = '0;
  localparam cadpcm_pkg::out_t ZeroA   =
    '{16'sd0, cadpcm_pkg::KindSample, 1'b0, 1'b1, 1'b0, 1'b0};
  localparam cadpcm_pkg::out_t ZeroB   =
    '{16'sd0, cadpcm_pkg::KindSample, 1'b0, 1'b1, 1'b0, 1'b1};
  localparam cadpcm_pkg::out_t PeakA   =
    '{16'sd28672, cadpcm_pkg::KindSample, 1'b0, 1'b1, 1'b0, 1'b0};
  localparam cadpcm_pkg::out_t PeakB   =
    '{16'sd28672, cadpcm_pkg::KindSample, 1'b0, 1'b1, 1'b0, 1'b1};
  localparam cadpcm_pkg::out_t FloorA  =
    '{-16'sd32767, cadpcm_pkg::KindSample, 1'b0, 1'b1, 1'b0, 1'b0};
  localparam cadpcm_pkg::out_t FloorB  =
    '{-16'sd32767, cadpcm_pkg::KindSample, 1'b0, 1'b1, 1'b0, 1'b1};
  localparam cadpcm_pkg::out_t EndMark =
    '{16'sd0, cadpcm_pkg::KindEnd, 1'b0, 1'b0, 1'b0, 1'b1};

  typedef struct {
    logic [7:0]       data;
    logic             sos;
    int               reps;
    bit               typed;
    cadpcm_pkg::out_t want_a;
    cadpcm_pkg::out_t want_b;
  } step_t;

  localparam int NumSteps = 17;
  step_t script [NumSteps] = '{
    // leading block with no start mark after reset: dropped
    '{8'h3C, 1'b0, 16, 1'b0, Quiet, Quiet},
    // predictor code 12 acts as 0; flag bits above bit 2 ignored
    '{8'hC0, 1'b0, 1, 1'b0, Quiet, Quiet},
    '{8'hFB, 1'b0, 1, 1'b0, Quiet, Quiet},
    '{8'h00, 1'b0, 1, 1'b1, ZeroA, ZeroB},
    '{8'h77, 1'b0, 1, 1'b1, PeakA, PeakB},
    '{8'h88, 1'b0, 1, 1'b1, FloorA, FloorB},
    '{8'hF7, 1'b0, 1, 1'b0, Quiet, Quiet},
    '{8'h9E, 1'b0, 10, 1'b0, Quiet, Quiet},
    // first-order filter driven hard positive
    '{8'h10, 1'b0, 1, 1'b0, Quiet, Quiet},
    '{8'h05, 1'b0, 1, 1'b0, Quiet, Quiet},
    '{8'h77, 1'b0, 14, 1'b0, Quiet, Quiet},
    // second-order filter driven hard negative
    '{8'h20, 1'b0, 1, 1'b0, Quiet, Quiet},
    '{8'h02, 1'b0, 1, 1'b0, Quiet, Quiet},
    '{8'h88, 1'b0, 14, 1'b0, Quiet, Quiet},
    // end marker, then bytes that must be ignored
    '{8'h4F, 1'b0, 1, 1'b0, Quiet, Quiet},
    '{cadpcm_pkg::FlagEnd, 1'b0, 1, 1'b1, EndMark, Quiet},
    '{8'hFF, 1'b0, 3, 1'b0, Quiet, Quiet}
  };

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             in_valid  = 1'b0;
  cadpcm_pkg::in_t  in_beat   = '0;
  logic             out_ready = 1'b0;
  logic             in_ready;
  logic             out_valid;
  cadpcm_pkg::out_t out_beat;

  always #10 clk_i = ~clk_i;

  console_adpcm_block_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_beat)
  );

  // Decoder state as the byte stream advances
  logic [3:0] blk_pos      = '0;
  bit         lead_pending = 1'b1;
  bit         halted       = 1'b0;
  logic [3:0] shift_amt    = '0;
  logic [2:0] filter_sel   = '0;
  logic [2:0] blk_flags    = '0;
  longint     hist_new     = 0;
  longint     hist_old     = 0;

  cadpcm_pkg::out_t expected_samples [$];
  int               sent_beats    = 0;
  int               samples_seen  = 0;
  int               mismatches    = 0;
  int               quiet_cycles  = 0;
  int               seq_count     = 0;
  bit               calm          = 1'b0;
  cadpcm_pkg::out_t oldest;

  function automatic void queue_expected(cadpcm_pkg::out_t s);
    expected_samples = {expected_samples, s};
  endfunction

  function automatic logic signed [15:0] nibble_to_pcm(logic [3:0] nib);
    longint x;
    longint acc;
    longint nv;
    longint q;
    x   = longint'($signed(nib)) * 4096;
    x   = x >>> shift_amt;
    acc = x * (longint'(1) <<< Frac) * 64
        + WeightNew[filter_sel] * hist_new + WeightOld[filter_sel] * hist_old;
    nv  = acc >>> 6;
    if (nv > HistMax) nv = HistMax;
    if (nv < HistMin) nv = HistMin;
    hist_old = hist_new;
    hist_new = nv;
    // round half up, then truncate toward zero
    q = (nv + (longint'(1) <<< (Frac - 1))) / (longint'(1) <<< Frac);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return 16'(q);
  endfunction

  function automatic cadpcm_pkg::out_t make_sample(logic signed [15:0] pcm, logic last);
    cadpcm_pkg::out_t s;
    s.pcm_sample      = pcm;
    s.result_kind     = cadpcm_pkg::KindSample;
    s.loop_start_mark = blk_flags[2];
    s.loop_end_mark   = blk_flags[0];
    s.release_mark    = blk_flags[0] & ~blk_flags[1];
    s.last_of_run     = last;
    return s;
  endfunction

  function automatic int decode_beat(cadpcm_pkg::in_t beat, output cadpcm_pkg::out_t first,
                                     output cadpcm_pkg::out_t second);
    logic [3:0] pos;
    first  = '0;
    second = '0;
    if (beat.start_of_sample) begin
      blk_pos      = '0;
      lead_pending = 1'b1;
      halted       = 1'b0;
      hist_new     = 0;
      hist_old     = 0;
    end
    if (halted) return 0;
    pos     = blk_pos;
    blk_pos = pos + 4'd1;
    if (lead_pending) begin
      if (pos == cadpcm_pkg::PosLast) lead_pending = 1'b0;
      return 0;
    end
    if (pos == cadpcm_pkg::PosHeader) begin
      shift_amt  = beat.data_byte[3:0];
      filter_sel = (beat.data_byte[7:4] < NumFilters) ? beat.data_byte[6:4] : 3'd0;
      return 0;
    end
    if (pos == cadpcm_pkg::PosFlags) begin
      if (beat.data_byte == cadpcm_pkg::FlagEnd) begin
        halted  = 1'b1;
        blk_pos = '0;
        first   = EndMark;
        return 1;
      end
      blk_flags = beat.data_byte[2:0];
      return 0;
    end
    first  = make_sample(nibble_to_pcm(beat.data_byte[3:0]), 1'b0);
    second = make_sample(nibble_to_pcm(beat.data_byte[7:4]), 1'b1);
    return 2;
  endfunction

  function automatic void flag_mismatch(string field, longint want, longint got);
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    mismatches++;
  endfunction

  // Present one beat, hold it until accepted, then predict what it yields
  task automatic offer(logic [7:0] data, logic sos, bit typed = 1'b0,
                       cadpcm_pkg::out_t want_a = '0, cadpcm_pkg::out_t want_b = '0);
    cadpcm_pkg::in_t  beat;
    cadpcm_pkg::out_t first;
    cadpcm_pkg::out_t second;
    int               n;
    beat.data_byte       = data;
    beat.start_of_sample = sos;
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_beat  <= beat;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sent_beats++;
    n = decode_beat(beat, first, second);
    if (n > 0) queue_expected(typed ? want_a : first);
    if (n > 1) queue_expected(typed ? want_b : second);
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] random_header();
    if ($urandom_range(99) < 70) return {4'($urandom_range(0, NumFilters - 1)), 4'($urandom)};
    return 8'($urandom);
  endfunction

  // Well-formed sample: start mark, leading block, a few blocks, usually an end marker
  task automatic random_sample();
    int         blocks;
    logic [7:0] flag;
    blocks = $urandom_range(1, 4);
    offer(8'($urandom), 1'b1);
    repeat (15) offer(8'($urandom), 1'b0);
    repeat (blocks) begin
      flag = 8'($urandom);
      if (flag == cadpcm_pkg::FlagEnd) flag = 8'h00;
      offer(random_header(), 1'b0);
      offer(flag, 1'b0);
      repeat (14) offer(8'($urandom), 1'b0);
    end
    if ($urandom_range(99) < 70) begin
      offer(random_header(), 1'b0);
      offer(cadpcm_pkg::FlagEnd, 1'b0);
      repeat ($urandom_range(0, 3)) offer(8'($urandom), 1'b0);
    end
  endtask

  // Raw bytes with stray start marks: truncated blocks and restarts
  task automatic noise_burst();
    int len;
    len = $urandom_range(1, 24);
    repeat (len) offer(8'($urandom), $urandom_range(99) < 10);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (script[s]) begin
      for (int r = 0; r < script[s].reps; r++) begin
        offer(script[s].data, script[s].sos, script[s].typed, script[s].want_a,
              script[s].want_b);
      end
    end
    while (sent_beats < ItemTarget) begin
      calm = (seq_count >= 10 && seq_count < 18);
      if ($urandom_range(99) < 15) noise_burst();
      else random_sample();
      seq_count++;
    end
    calm = 1'b0;
    in_valid <= 1'b0;
    wait (expected_samples.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // Output side: random stalls, plus one long hold-off so the input backs up
  initial begin
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && samples_seen >= HoldOffAfter) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
      end
      else begin
        out_ready <= calm || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        samples_seen++;
        if (expected_samples.size() == 0) begin
          $display("%0t ns: unexpected beat, got %p", $time, out_beat);
          mismatches++;
        end
        else begin
          oldest = expected_samples.pop_front();
          if (out_beat.pcm_sample !== oldest.pcm_sample)
            flag_mismatch("pcm_sample", oldest.pcm_sample, out_beat.pcm_sample);
          if (out_beat.result_kind !== oldest.result_kind)
            flag_mismatch("result_kind", oldest.result_kind, out_beat.result_kind);
          if (out_beat.loop_start_mark !== oldest.loop_start_mark)
            flag_mismatch("loop_start_mark", oldest.loop_start_mark, out_beat.loop_start_mark);
          if (out_beat.loop_end_mark !== oldest.loop_end_mark)
            flag_mismatch("loop_end_mark", oldest.loop_end_mark, out_beat.loop_end_mark);
          if (out_beat.release_mark !== oldest.release_mark)
            flag_mismatch("release_mark", oldest.release_mark, out_beat.release_mark);
          if (out_beat.last_of_run !== oldest.last_of_run)
            flag_mismatch("last_of_run", oldest.last_of_run, out_beat.last_of_run);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule
